@@ hdl/scr_pkg.sv @@
package scr_pkg;

    // Horner accumulator width, Q16 coefficients
    localparam int ACC_W = 52;
    // fraction and squared fraction, Q32 with room for one
    localparam int X_W = 33;
    localparam int PL_W = 32 + X_W;
    localparam int PH_W = ACC_W - 32 + X_W;
    localparam int STEPS = 6;

    // 2/pi in two Q32 halves
    localparam logic [31:0] TWO_OVER_PI_HI = 32'hA2F9836E;
    localparam logic [31:0] TWO_OVER_PI_LO = 32'h4E441529;

    typedef logic signed [ACC_W-1:0] acc_t;
    typedef acc_t acc_arr_t [STEPS];

    // leading coefficients, Q16
    localparam acc_t NUM_C5 = ACC_W'(-64'sd583 * 64'sd65536);
    localparam acc_t DEN_C5 = ACC_W'(64'sd1 * 64'sd65536);

    // coefficient added after each Horner step; the last step only scales by x
    localparam acc_arr_t NUM_ADD = '{
        ACC_W'(64'sd100209 * 64'sd65536),
        ACC_W'(-64'sd6351332 * 64'sd65536),
        ACC_W'(64'sd172431478 * 64'sd65536),
        ACC_W'(-64'sd1808816671 * 64'sd65536),
        ACC_W'(64'sd4857791910 * 64'sd65536),
        ACC_W'(0)
    };
    localparam acc_arr_t DEN_ADD = '{
        ACC_W'(64'sd229 * 64'sd65536),
        ACC_W'(64'sd28483 * 64'sd65536),
        ACC_W'(64'sd2321428 * 64'sd65536),
        ACC_W'(64'sd120238491 * 64'sd65536),
        ACC_W'(64'sd3092566380 * 64'sd65536),
        ACC_W'(0)
    };

    localparam logic [1:0] QUAD_SIN_POS = 2'd0;
    localparam logic [1:0] QUAD_COS = 2'd1;
    localparam logic [1:0] QUAD_SIN_NEG = 2'd2;
    localparam logic [1:0] QUAD_ONE_NEG = 2'd3;

endpackage

@@ hdl/sine_cosine_rational.sv @@
// The pipe is built from the angle reduction (4 stages), six Horner
// steps of two stages each and a restoring divider that resolves one
// quotient bit per stage.
// Throughput: one word per cycle; a stall on the output holds the whole pipe.
// Reset clears the valid bits only; the data path registers are not reset.
module sine_cosine_rational #(
    parameter int ANGLE_FRAC_BITS = 24,
    parameter int OUT_FRAC_BITS = 30
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic signed [31:0] angle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] value
);

    localparam int ACC_W = scr_pkg::ACC_W;
    localparam int X_W = scr_pkg::X_W;
    localparam int PL_W = scr_pkg::PL_W;
    localparam int PH_W = scr_pkg::PH_W;
    localparam int STEPS = scr_pkg::STEPS;
    localparam int HS = 2 * STEPS;
    localparam int QB = OUT_FRAC_BITS + 3;
    localparam int NV = 5 + HS + QB;
    localparam int DW = ACC_W - 3;
    localparam int RW = DW + 2;
    localparam int MW = OUT_FRAC_BITS + 2;

    logic en;
    logic [NV-1:0] v_reg;

    // reduction stages
    logic [31:0] a_reg;
    logic [1:0]  qb_reg, qb2_reg, q3_reg, q4_reg;
    logic [63:0] ph64_reg, pl64_reg;
    logic [X_W-1:0] x_reg, x4_reg;
    logic zr3_reg, zr4_reg;
    logic [2*X_W-1:0] sq_reg;

    // Horner stages
    logic [X_W-1:0] hx_reg [HS];
    logic [X_W-1:0] hz_reg [HS];
    logic [1:0]     hq_reg [HS];
    logic           hzr_reg [HS];
    logic           pneg_reg [STEPS];
    logic           dneg_reg [STEPS];
    logic [PL_W-1:0] ppl_reg [STEPS];
    logic [PH_W-1:0] pph_reg [STEPS];
    logic [PL_W-1:0] dpl_reg [STEPS];
    logic [PH_W-1:0] dph_reg [STEPS];
    scr_pkg::acc_t  pacc_reg [STEPS];
    scr_pkg::acc_t  dacc_reg [STEPS];

    // divider stages
    logic [RW-1:0] dr_reg [QB];
    logic [DW-1:0] dd_reg [QB];
    logic [QB-1:0] dq_reg [QB];
    logic [1:0]    dquad_reg [QB];
    logic          dzero_reg [QB];

    logic signed [31:0] value_reg;

    // combinational
    logic [31:0] a_next;
    logic [1:0]  qb_next;
    logic [63:0] u;
    logic [1:0]  quad3;
    logic [31:0] x0;
    logic [X_W-1:0] sx_in [HS];
    logic [X_W-1:0] sz_in [HS];
    logic [1:0]     sq_in [HS];
    logic           szr_in [HS];
    scr_pkg::acc_t  pin [STEPS];
    scr_pkg::acc_t  din [STEPS];
    logic [ACC_W-1:0] pm [STEPS];
    logic [ACC_W-1:0] dm [STEPS];
    logic [X_W-1:0] mul [STEPS];
    logic [X_W-1:0] dmul [STEPS];
    scr_pkg::acc_t  pacc_next [STEPS];
    scr_pkg::acc_t  dacc_next [STEPS];
    logic [PH_W:0]  pr [STEPS];
    logic [PH_W:0]  dr [STEPS];
    logic [RW-1:0] rin [QB];
    logic [DW-1:0] din_d [QB];
    logic [QB-1:0] qin [QB];
    logic [RW-1:0] rsh [QB];
    logic [RW-1:0] dtr [QB];
    logic [RW-1:0] r_next [QB];
    logic [QB-1:0] q_next [QB];
    logic [MW-1:0] rnd;
    logic [MW-1:0] magc;
    logic [MW-1:0] one;
    logic signed [31:0] value_next;

    assign en = !v_reg[NV-1] || out_ready;
    assign in_ready = en;
    assign out_valid = v_reg[NV-1];
    assign value = value_reg;

    always_comb
    begin
        a_next = angle[31] ? (~angle + 32'd1) : angle;
        if (cmd)
            qb_next = scr_pkg::QUAD_COS;
        else if (angle[31])
            qb_next = scr_pkg::QUAD_SIN_NEG;
        else
            qb_next = scr_pkg::QUAD_SIN_POS;

        u = ph64_reg + {32'd0, pl64_reg[63:32]};
        quad3 = qb2_reg + u[ANGLE_FRAC_BITS+33:ANGLE_FRAC_BITS+32];
        x0 = u[ANGLE_FRAC_BITS+31:ANGLE_FRAC_BITS];
    end

    always_comb
    begin
        for (int h = 0; h < HS; h++)
        begin
            if (h == 0)
            begin
                sx_in[h] = x4_reg;
                sz_in[h] = sq_reg[2*X_W-2:32];
                sq_in[h] = q4_reg;
                szr_in[h] = zr4_reg;
            end
            else
            begin
                sx_in[h] = hx_reg[h-1];
                sz_in[h] = hz_reg[h-1];
                sq_in[h] = hq_reg[h-1];
                szr_in[h] = hzr_reg[h-1];
            end
        end
        for (int s = 0; s < STEPS; s++)
        begin
            if (s == 0)
            begin
                pin[s] = scr_pkg::NUM_C5;
                din[s] = scr_pkg::DEN_C5;
            end
            else
            begin
                pin[s] = pacc_reg[s-1];
                din[s] = dacc_reg[s-1];
            end
            pm[s] = pin[s][ACC_W-1] ? ACC_W'(-pin[s]) : ACC_W'(pin[s]);
            dm[s] = din[s][ACC_W-1] ? ACC_W'(-din[s]) : ACC_W'(din[s]);
            mul[s] = (s == STEPS - 1) ? sx_in[2*s] : sz_in[2*s];
            // the denominator only rides through the last step, scaled by one
            dmul[s] = (s == STEPS - 1) ? (X_W'(1) << 32) : sz_in[2*s];
            // floor of magnitude times multiplicand over 2^32, sign restored
            pr[s] = {1'b0, pph_reg[s]} + (PH_W+1)'(ppl_reg[s][PL_W-1:32]);
            dr[s] = {1'b0, dph_reg[s]} + (PH_W+1)'(dpl_reg[s][PL_W-1:32]);
            pacc_next[s] = (pneg_reg[s] ? -ACC_W'(pr[s]) : ACC_W'(pr[s]))
                           + scr_pkg::NUM_ADD[s];
            dacc_next[s] = (dneg_reg[s] ? -ACC_W'(dr[s]) : ACC_W'(dr[s]))
                           + scr_pkg::DEN_ADD[s];
        end
    end

    always_comb
    begin
        for (int j = 0; j < QB; j++)
        begin
            if (j == 0)
            begin
                rin[j] = pacc_reg[STEPS-1][ACC_W-1] ? '0
                         : RW'(pacc_reg[STEPS-1][ACC_W-2:0]);
                din_d[j] = (pacc_reg[STEPS-1][ACC_W-1] || dacc_reg[STEPS-1] == '0
                            || dacc_reg[STEPS-1][ACC_W-1])
                           ? DW'(1) : dacc_reg[STEPS-1][DW-1:0];
                qin[j] = '0;
            end
            else
            begin
                rin[j] = dr_reg[j-1];
                din_d[j] = dd_reg[j-1];
                qin[j] = dq_reg[j-1];
            end
            // two integer bits first, then one fraction bit a stage
            rsh[j] = (j >= 2) ? {rin[j][RW-2:0], 1'b0} : rin[j];
            dtr[j] = (j == 0) ? {1'b0, din_d[j], 1'b0} : {2'b00, din_d[j]};
            if (rsh[j] >= dtr[j])
            begin
                r_next[j] = rsh[j] - dtr[j];
                q_next[j] = {qin[j][QB-2:0], 1'b1};
            end
            else
            begin
                r_next[j] = rsh[j];
                q_next[j] = {qin[j][QB-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        one = MW'(1) << OUT_FRAC_BITS;
        rnd = MW'(({1'b0, dq_reg[QB-1]} + (QB+1)'(1)) >> 1);
        magc = (rnd > one) ? one : rnd;
        if (dzero_reg[QB-1])
        begin
            if (dquad_reg[QB-1] == scr_pkg::QUAD_COS)
                value_next = 32'(one);
            else if (dquad_reg[QB-1] == scr_pkg::QUAD_ONE_NEG)
                value_next = -32'(one);
            else
                value_next = '0;
        end
        else if (dquad_reg[QB-1][1])
            value_next = -32'(magc);
        else
            value_next = 32'(magc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NV-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_next;
            qb_reg <= qb_next;

            ph64_reg <= 64'(a_reg) * 64'(scr_pkg::TWO_OVER_PI_HI);
            pl64_reg <= 64'(a_reg) * 64'(scr_pkg::TWO_OVER_PI_LO);
            qb2_reg <= qb_reg;

            q3_reg <= quad3;
            zr3_reg <= (x0 == 32'd0);
            // mirror the fraction in odd quadrants
            x_reg <= quad3[0] ? ((X_W'(1) << 32) - X_W'(x0)) : X_W'(x0);

            sq_reg <= (2*X_W)'(x_reg) * (2*X_W)'(x_reg);
            x4_reg <= x_reg;
            q4_reg <= q3_reg;
            zr4_reg <= zr3_reg;

            for (int h = 0; h < HS; h++)
            begin
                hx_reg[h] <= sx_in[h];
                hz_reg[h] <= sz_in[h];
                hq_reg[h] <= sq_in[h];
                hzr_reg[h] <= szr_in[h];
            end
            for (int s = 0; s < STEPS; s++)
            begin
                pneg_reg[s] <= pin[s][ACC_W-1];
                dneg_reg[s] <= din[s][ACC_W-1];
                ppl_reg[s] <= PL_W'(pm[s][31:0]) * PL_W'(mul[s]);
                pph_reg[s] <= PH_W'(pm[s][ACC_W-1:32]) * PH_W'(mul[s]);
                dpl_reg[s] <= PL_W'(dm[s][31:0]) * PL_W'(dmul[s]);
                dph_reg[s] <= PH_W'(dm[s][ACC_W-1:32]) * PH_W'(dmul[s]);
                pacc_reg[s] <= pacc_next[s];
                dacc_reg[s] <= dacc_next[s];
            end

            for (int j = 0; j < QB; j++)
            begin
                dr_reg[j] <= r_next[j];
                dd_reg[j] <= din_d[j];
                dq_reg[j] <= q_next[j];
                dquad_reg[j] <= (j == 0) ? hq_reg[HS-1] : dquad_reg[j-1];
                dzero_reg[j] <= (j == 0) ? hzr_reg[HS-1] : dzero_reg[j-1];
            end

            value_reg <= value_next;
        end
    end

endmodule

@@ dv/sine_cosine_rational_tb.sv @@
`timescale 1ns / 1ps

module sine_cosine_rational_tb;

    localparam int ANG_FB = 24;
    localparam int OUT_FB = 30;
    localparam int LATENCY = OUT_FB + 20;
    localparam int N_RANDOM = 1080;
    localparam int N_QUIET = 200;
    localparam logic CMD_SIN = 1'b0;
    localparam logic CMD_COS = 1'b1;
    // pi/2 in the angle format
    localparam int HALF_PI = 26353589;
    localparam logic signed [31:0] ONE_OUT = 32'sd1 <<< OUT_FB;

    typedef struct {
        logic              cmd;
        logic signed [31:0] angle;
        bit                typed;
        logic signed [31:0] want;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               cmd = 1'b0;
    logic signed [31:0] angle = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] value;

    logic signed [31:0] trig_q[$];
    int  n_errors = 0;
    int  n_words_out = 0;
    int  n_sin = 0;
    int  n_cos = 0;
    bit  quiet = 1'b0;
    int  rx_stall = 0;

    always #6 clk = ~clk;

    sine_cosine_rational i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .angle(angle),
        .out_valid(out_valid), .out_ready(out_ready), .value(value)
    );

    function automatic longint scale_q32(longint v, longint unsigned z);
        longint unsigned m;
        longint unsigned r;
        m = (v < 0) ? -v : v;
        r = (m >> 32) * z + (((m & 64'hFFFF_FFFF) * z) >> 32);
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic signed [31:0] trig_value(logic c, logic signed [31:0] ang);
        longint num_c[6];
        longint den_c[6];
        longint unsigned a, u, x, z, n, d, qt, r, mag;
        longint pn, pd, nn;
        logic [1:0] quad;
        num_c = '{64'sd4857791910, -64'sd1808816671, 64'sd172431478,
                  -64'sd6351332, 64'sd100209, -64'sd583};
        den_c = '{64'sd3092566380, 64'sd120238491, 64'sd2321428,
                  64'sd28483, 64'sd229, 64'sd1};
        a = ang[31] ? (64'h1_0000_0000 - {32'd0, ang}) : {32'd0, ang};
        if (c == CMD_COS)
            quad = scr_pkg::QUAD_COS;
        else if (ang[31])
            quad = scr_pkg::QUAD_SIN_NEG;
        else
            quad = scr_pkg::QUAD_SIN_POS;
        u = a * {32'd0, scr_pkg::TWO_OVER_PI_HI}
            + ((a * {32'd0, scr_pkg::TWO_OVER_PI_LO}) >> 32);
        quad = quad + 2'(u >> (ANG_FB + 32));
        x = (u >> ANG_FB) & 64'hFFFF_FFFF;
        if (x == 0)
        begin
            if (quad == scr_pkg::QUAD_COS)
                return ONE_OUT;
            if (quad == scr_pkg::QUAD_ONE_NEG)
                return -ONE_OUT;
            return 0;
        end
        if (quad[0])
            x = 64'h1_0000_0000 - x;
        z = (x == 64'h1_0000_0000) ? x : ((x * x) >> 32);
        pn = num_c[5] * 65536;
        pd = den_c[5] * 65536;
        for (int i = 4; i >= 0; i--)
        begin
            pn = scale_q32(pn, z) + num_c[i] * 65536;
            pd = scale_q32(pd, z) + den_c[i] * 65536;
        end
        nn = scale_q32(pn, x);
        n = (nn < 0) ? 0 : nn;
        d = (pd <= 0) ? 1 : pd;
        qt = n / d;
        r = n % d;
        for (int i = 0; i < OUT_FB + 1; i++)
        begin
            r = r << 1;
            qt = qt << 1;
            if (r >= d)
            begin
                r = r - d;
                qt = qt | 1;
            end
        end
        mag = (qt + 1) >> 1;
        if (mag > (64'd1 << OUT_FB))
            mag = 64'd1 << OUT_FB;
        if (quad > 1)
            mag = -mag;
        return mag[31:0];
    endfunction

    task automatic report_mismatch(string what);
        n_errors++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // one word into the block; idle first at random unless in the quiet tail
    task automatic send_word(logic c, logic signed [31:0] ang, bit typed,
                             logic signed [31:0] want);
        logic signed [31:0] calc;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        angle <= ang;
        do
            @(posedge clk);
        while (!in_ready);
        calc = trig_value(c, ang);
        if (typed && calc != want)
            report_mismatch($sformatf("table entry cmd=%0d angle=%0d: %0d, predictor %0d",
                                      c, ang, want, calc));
        trig_q.push_back(typed ? want : calc);
        if (c == CMD_COS)
            n_cos++;
        else
            n_sin++;
    endtask

    always @(posedge clk)
    begin
        logic signed [31:0] want;
        if (out_valid && out_ready)
        begin
            n_words_out++;
            if (trig_q.size() == 0)
                report_mismatch($sformatf("unexpected word value=%0d", value));
            else
            begin
                want = trig_q.pop_front();
                if (value !== want)
                    report_mismatch($sformatf("value %0d, expected %0d", value, want));
            end
        end
        // receiver stalls in bursts
        if (rx_stall > 0)
        begin
            rx_stall <= rx_stall - 1;
            out_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            rx_stall <= $urandom_range(0, 2);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        stim_row_t rows[$];
        logic signed [31:0] ang;
        int k;
        rows = '{
            '{CMD_SIN, 32'sd0, 1'b1, 32'sd0},
            '{CMD_COS, 32'sd0, 1'b1, ONE_OUT},
            '{CMD_SIN, 32'sd1, 1'b0, 32'sd0},
            '{CMD_COS, 32'sd1, 1'b0, 32'sd0},
            '{CMD_SIN, -32'sd1, 1'b0, 32'sd0},
            '{CMD_COS, -32'sd1, 1'b0, 32'sd0},
            '{CMD_SIN, 32'sh7FFF_FFFF, 1'b0, 32'sd0},
            '{CMD_COS, 32'sh7FFF_FFFF, 1'b0, 32'sd0},
            '{CMD_SIN, 32'sh8000_0000, 1'b0, 32'sd0},
            '{CMD_COS, 32'sh8000_0000, 1'b0, 32'sd0},
            '{CMD_SIN, HALF_PI, 1'b0, 32'sd0},
            '{CMD_COS, HALF_PI, 1'b0, 32'sd0},
            '{CMD_SIN, 2 * HALF_PI, 1'b0, 32'sd0},
            '{CMD_COS, 2 * HALF_PI, 1'b0, 32'sd0},
            '{CMD_SIN, 3 * HALF_PI, 1'b0, 32'sd0},
            '{CMD_COS, 3 * HALF_PI, 1'b0, 32'sd0},
            '{CMD_SIN, -HALF_PI, 1'b0, 32'sd0},
            '{CMD_COS, -3 * HALF_PI, 1'b0, 32'sd0},
            '{CMD_SIN, 32'sh0100_0000, 1'b0, 32'sd0},
            '{CMD_COS, -32'sh0100_0000, 1'b0, 32'sd0},
            '{CMD_SIN, 32'sh5555_5555, 1'b0, 32'sd0},
            '{CMD_COS, 32'shAAAA_AAAA, 1'b0, 32'sd0}
        };
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_word(rows[i].cmd, rows[i].angle, rows[i].typed, rows[i].want);

        // hold off until the pipe has drained
        in_valid <= 1'b0;
        while (trig_q.size() != 0)
            @(posedge clk);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM - N_QUIET)
                quiet = 1'b1;
            case ($urandom_range(0, 3))
                0: ang = $urandom;
                1: ang = $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
                2:
                begin
                    // near a quadrant boundary
                    k = $urandom_range(0, 160) - 80;
                    ang = k * HALF_PI + $signed($urandom_range(0, 64)) - 32;
                end
                default: ang = $signed($urandom_range(0, 2 * HALF_PI)) - HALF_PI;
            endcase
            send_word(1'($urandom_range(0, 1)), ang, 1'b0, 32'sd0);
        end
        in_valid <= 1'b0;

        while (trig_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        $display("Covered %0d sine and %0d cosine angles, %0d results checked,",
                 n_sin, n_cos, n_words_out);
        $display("with quadrant edges, extreme angles and stalls on both sides.");
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/scr_pkg.sv
hdl/sine_cosine_rational.sv
dv/sine_cosine_rational_tb.sv
